// File: hw/rtl/lru_key_value_cache_defines.svh
// Assertion macros used by the top-level cache file.
`ifndef LRU_KEY_VALUE_CACHE_DEFINES_SVH
`define LRU_KEY_VALUE_CACHE_DEFINES_SVH
// Implication checked at every rising clock edge outside reset.
`define LKV_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define LKV_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// File: hw/rtl/lkv_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LRU key-value cache package
// Shared widths, request and result types, control structs.
// ----------------------------------------------------------------------------
package lkv_pkg;
  localparam int MaxEntries = 16;
  localparam int KeyBits = 32;
  localparam int ValueBits = 32;
  localparam int IdxBits = $clog2(MaxEntries);
  localparam int CntBits = $clog2(MaxEntries + 1);
  localparam int CapBits = 5;
  localparam logic CmdGet = 1'b0;
  localparam logic CmdPut = 1'b1;

  typedef struct packed {
    logic cmd;
    logic signed [KeyBits-1:0] key;
    logic signed [ValueBits-1:0] value;
  } req_t;

  typedef struct packed {
    logic hit;
    logic signed [ValueBits-1:0] read_value;
    logic evicted;
    logic signed [KeyBits-1:0] evicted_key;
  } rsp_t;

  typedef struct packed {
    logic exec;
  } lkv_cmd_t;

  typedef struct packed {
    logic done;
  } lkv_status_t;
endpackage
`default_nettype wire

// File: hw/rtl/lkv_stream_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Request and response channel interfaces
// Valid/ready channels, each carrying one packed payload.
// ----------------------------------------------------------------------------
interface lkv_req_if;
  import lkv_pkg::*;
  logic valid;
  logic ready;
  req_t payload;
  modport source(output valid, output payload, input ready);
  modport sink(input valid, input payload, output ready);
endinterface

interface lkv_rsp_if;
  import lkv_pkg::*;
  logic valid;
  logic ready;
  rsp_t payload;
  modport source(output valid, output payload, input ready);
  modport sink(input valid, input payload, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/lkv_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LRU cache datapath
// Entry store with parallel key match, recency ranks and victim selection.
// ----------------------------------------------------------------------------
module lkv_datapath (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cap_we,
  input  wire logic [lkv_pkg::CapBits-1:0] cap_wdata,
  input  wire lkv_pkg::lkv_cmd_t ctl,
  input  wire lkv_pkg::req_t req,
  output lkv_pkg::rsp_t rsp,
  output lkv_pkg::lkv_status_t stat
);
  import lkv_pkg::*;

  logic [MaxEntries-1:0] vld;
  logic [KeyBits-1:0] keys [MaxEntries];
  logic [ValueBits-1:0] vals [MaxEntries];
  logic [IdxBits-1:0] rank [MaxEntries];
  logic [CntBits-1:0] occ;
  logic [CapBits-1:0] cap;
  logic [CntBits-1:0] eff_cap;
  logic [MaxEntries-1:0] match;
  logic [MaxEntries-1:0] is_victim;
  logic [MaxEntries-1:0] free_after;
  logic [MaxEntries-1:0] slot_oh;
  logic found;
  logic do_evict;
  logic do_fill;
  logic [IdxBits-1:0] hit_rank;
  logic [ValueBits-1:0] hit_val;
  logic [KeyBits-1:0] vic_key;

  always_comb begin
    if (cap == '0) begin
      eff_cap = CntBits'(1);
    end else if (32'(cap) > MaxEntries) begin
      eff_cap = CntBits'(MaxEntries);
    end else begin
      eff_cap = CntBits'(cap);
    end
  end

  always_comb begin
    match = '0;
    is_victim = '0;
    for (int i = 0; i < MaxEntries; i++) begin
      match[i] = vld[i] && (keys[i] == req.key);
      is_victim[i] = vld[i] && (32'(rank[i]) == 32'(occ) - 1);
    end
  end

  always_comb begin
    found = 1'b0;
    hit_rank = '0;
    hit_val = '0;
    vic_key = '0;
    for (int i = MaxEntries - 1; i >= 0; i--) begin
      if (match[i]) begin
        found = 1'b1;
        hit_rank = rank[i];
        hit_val = vals[i];
      end
      if (is_victim[i]) begin
        vic_key = keys[i];
      end
    end
  end

  assign do_fill = !found && req.cmd == CmdPut;
  assign do_evict = do_fill && occ >= eff_cap && occ != '0;
  assign free_after = ~(vld & ~(do_evict ? is_victim : '0));
  assign slot_oh = free_after & (~free_after + MaxEntries'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      occ <= '0;
      cap <= CapBits'(16);
      stat <= '0;
    end else begin
      stat.done <= ctl.exec;
      if (cap_we) begin
        cap <= cap_wdata;
      end
      if (ctl.exec) begin
        rsp.hit <= found;
        rsp.read_value <= (found && req.cmd == CmdGet) ? hit_val : '0;
        rsp.evicted <= do_evict;
        rsp.evicted_key <= do_evict ? vic_key : '0;
        if (found) begin
          for (int i = 0; i < MaxEntries; i++) begin
            if (match[i]) begin
              rank[i] <= '0;
              if (req.cmd == CmdPut) begin
                vals[i] <= req.value;
              end
            end else if (vld[i] && rank[i] < hit_rank) begin
              rank[i] <= rank[i] + IdxBits'(1);
            end
          end
        end else if (do_fill) begin
          for (int i = 0; i < MaxEntries; i++) begin
            if (slot_oh[i]) begin
              vld[i] <= 1'b1;
              keys[i] <= req.key;
              vals[i] <= req.value;
              rank[i] <= '0;
            end else if (do_evict && is_victim[i]) begin
              vld[i] <= 1'b0;
            end else if (vld[i]) begin
              rank[i] <= rank[i] + IdxBits'(1);
            end
          end
          if (!do_evict) begin
            occ <= occ + CntBits'(1);
          end
        end
      end
    end
  end
endmodule
`default_nettype wire

// File: hw/rtl/lkv_controller.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LRU cache controller
// Takes one request, starts the datapath and holds the result until taken.
// ----------------------------------------------------------------------------
module lkv_controller (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  wire logic out_ready,
  output lkv_pkg::lkv_cmd_t ctl
);
  import lkv_pkg::*;

  typedef enum logic {
    ST_EMPTY,
    ST_FULL
  } state_t;

  state_t state;

  assign in_ready = state == ST_EMPTY || out_ready;
  assign ctl.exec = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_EMPTY;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        ST_EMPTY: begin
          if (ctl.exec) begin
            state <= ST_FULL;
            out_valid <= 1'b1;
          end
        end
        ST_FULL: begin
          if (out_ready && !ctl.exec) begin
            state <= ST_EMPTY;
            out_valid <= 1'b0;
          end
        end
        default: begin
          state <= ST_EMPTY;
          out_valid <= 1'b0;
        end
      endcase
    end
  end
endmodule
`default_nettype wire

// File: hw/rtl/lru_key_value_cache.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LRU key-value cache
// Sixteen-entry fully associative store with least-recently-used eviction.
// ----------------------------------------------------------------------------
// A request on req carries cmd (get or put), key and value. Each request
// gives exactly one result on rsp with hit, read_value, evicted and
// evicted_key. The key is compared against all entries in parallel and the
// recency ranks are updated in the same cycle, so the result is registered
// and appears in the cycle after its request is taken. One request is taken
// per cycle unless the receiver stalls; the output register is the only
// storage between the channels. When the receiver stalls, the held result
// stays on rsp and req.ready falls until it is taken, so no request is lost.
// The user must write the capacity register through cap_we and cap_wdata
// only while the block is idle; it does not enforce this. Zero acts as one
// and values above sixteen saturate. Reset empties the store and sets the capacity to sixteen.
// ----------------------------------------------------------------------------
module lru_key_value_cache (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cap_we,
  input  wire logic [lkv_pkg::CapBits-1:0] cap_wdata,
  lkv_req_if.sink req,
  lkv_rsp_if.source rsp
);
  import lkv_pkg::*;
  `include "lru_key_value_cache_defines.svh"

  lkv_cmd_t ctl;
  lkv_status_t stat;

  lkv_controller u_ctrl (
    .clk(clk),
    .rst(rst),
    .in_valid(req.valid),
    .in_ready(req.ready),
    .out_valid(rsp.valid),
    .out_ready(rsp.ready),
    .ctl(ctl)
  );

  lkv_datapath u_dp (
    .clk(clk),
    .rst(rst),
    .cap_we(cap_we),
    .cap_wdata(cap_wdata),
    .ctl(ctl),
    .req(req.payload),
    .rsp(rsp.payload),
    .stat(stat)
  );

  `LKV_ASSERT_NEXT(a_result_follows, clk, rst, ctl.exec, rsp.valid)
  `LKV_ASSERT_IMPL(a_done_valid, clk, rst, stat.done, rsp.valid)
  `LKV_ASSERT_IMPL(a_stall_blocks, clk, rst, rsp.valid && !rsp.ready, !req.ready)
endmodule
`default_nettype wire
